@@ hw/rtl/rce_pkg.sv @@
// Shared types, constants and mod-26 helpers for the rotor cipher engine.
// No dependencies; every other file depends on this package.
`timescale 1ns / 1ps

package rce_pkg;

  localparam int LETTERS    = 26;
  localparam int ROTORS     = 3;
  localparam int LETTER_W   = 5;
  localparam int TABLE_W    = 3;
  localparam int CMD_W      = 2;
  localparam int ROTOR_W    = 2;
  localparam int PADDR_W    = 4;
  localparam int PDATA_W    = 32;
  localparam int NUM_STAGES = 9;
  localparam int PIPE_DEPTH = NUM_STAGES + 1;

  typedef logic [LETTER_W-1:0] letter_t;
  typedef logic [ROTORS-1:0][LETTER_W-1:0] pos_t;
  typedef logic [ROTORS-1:0][LETTER_W-1:0] notch_t;

  localparam logic [CMD_W-1:0] CMD_ENCRYPT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SET     = 2'd2;

  localparam logic [TABLE_W-1:0] TBL_ROTOR_FAST = 3'd0;
  localparam logic [TABLE_W-1:0] TBL_ROTOR_MID  = 3'd1;
  localparam logic [TABLE_W-1:0] TBL_ROTOR_SLOW = 3'd2;
  localparam logic [TABLE_W-1:0] TBL_REFLECTOR  = 3'd3;
  localparam logic [TABLE_W-1:0] TBL_PLUG       = 3'd4;

  localparam logic [ROTOR_W-1:0] REG_NOTCH_FAST   = 2'd0;
  localparam logic [ROTOR_W-1:0] REG_NOTCH_MIDDLE = 2'd1;
  localparam logic [ROTOR_W-1:0] REG_NOTCH_SLOW   = 2'd2;

  // One item in flight; sym is the running letter of an encrypt item.
  typedef struct packed {
    logic                is_load;
    logic [TABLE_W-1:0]  table_id;
    letter_t             idx;
    letter_t             val;
    letter_t             sym;
    pos_t                pos;
  } item_t;

  typedef struct packed {
    logic [TABLE_W-1:0] tbl;
    logic               inverse;
    logic               use_pos;
    logic [ROTOR_W-1:0] rotor;
    logic               identity_reset;
  } stage_cfg_t;

  localparam stage_cfg_t STAGE_CFG [NUM_STAGES] = '{
    '{tbl: TBL_PLUG,       inverse: 1'b0, use_pos: 1'b0, rotor: 2'd0, identity_reset: 1'b1},
    '{tbl: TBL_ROTOR_FAST, inverse: 1'b0, use_pos: 1'b1, rotor: 2'd0, identity_reset: 1'b0},
    '{tbl: TBL_ROTOR_MID,  inverse: 1'b0, use_pos: 1'b1, rotor: 2'd1, identity_reset: 1'b0},
    '{tbl: TBL_ROTOR_SLOW, inverse: 1'b0, use_pos: 1'b1, rotor: 2'd2, identity_reset: 1'b0},
    '{tbl: TBL_REFLECTOR,  inverse: 1'b0, use_pos: 1'b0, rotor: 2'd0, identity_reset: 1'b0},
    '{tbl: TBL_ROTOR_SLOW, inverse: 1'b1, use_pos: 1'b1, rotor: 2'd2, identity_reset: 1'b0},
    '{tbl: TBL_ROTOR_MID,  inverse: 1'b1, use_pos: 1'b1, rotor: 2'd1, identity_reset: 1'b0},
    '{tbl: TBL_ROTOR_FAST, inverse: 1'b1, use_pos: 1'b1, rotor: 2'd0, identity_reset: 1'b0},
    '{tbl: TBL_PLUG,       inverse: 1'b0, use_pos: 1'b0, rotor: 2'd0, identity_reset: 1'b1}
  };

  function automatic letter_t mod26(input letter_t x);
    return (x >= letter_t'(LETTERS)) ? letter_t'(x - letter_t'(LETTERS)) : x;
  endfunction

  function automatic letter_t inc26(input letter_t x);
    return (x == letter_t'(LETTERS - 1)) ? '0 : letter_t'(x + 1'b1);
  endfunction

  function automatic letter_t add26(input letter_t a, input letter_t b);
    logic [LETTER_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s >= (LETTER_W+1)'(LETTERS)) ? letter_t'(s - (LETTER_W+1)'(LETTERS))
                                          : letter_t'(s);
  endfunction

  // Operands below 26; the wrap case stays below 26 so 5-bit math suffices.
  function automatic letter_t sub26(input letter_t a, input letter_t b);
    return (a >= b) ? letter_t'(a - b) : letter_t'(a + letter_t'(LETTERS) - b);
  endfunction

endpackage

@@ hw/rtl/rce_if.sv @@
// Valid/ready channel interfaces for the rotor cipher engine request and result.
// Depends on rce_pkg for field widths.
`timescale 1ns / 1ps

interface rce_in_if;
  logic                           valid;
  logic                           ready;
  logic [rce_pkg::CMD_W-1:0]      command;
  logic [rce_pkg::LETTER_W-1:0]   letter;
  logic [rce_pkg::TABLE_W-1:0]    table_id;
  logic [rce_pkg::LETTER_W-1:0]   entry_index;
  logic [rce_pkg::LETTER_W-1:0]   entry_value;
  logic [rce_pkg::ROTOR_W-1:0]    rotor_index;
  logic [rce_pkg::LETTER_W-1:0]   start_position;

  modport source (output valid, command, letter, table_id, entry_index, entry_value,
                  rotor_index, start_position, input ready);
  modport sink   (input valid, command, letter, table_id, entry_index, entry_value,
                  rotor_index, start_position, output ready);
endinterface

interface rce_out_if;
  logic                         valid;
  logic                         ready;
  logic [rce_pkg::LETTER_W-1:0] cipher_letter;

  modport source (output valid, cipher_letter, input ready);
  modport sink   (input valid, cipher_letter, output ready);
endinterface

@@ hw/rtl/rce_regs.sv @@
// APB register block holding the three rotor notch positions.
// Depends on rce_pkg.
`timescale 1ns / 1ps

module rce_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rce_pkg::PADDR_W-1:0]  paddr,
  input  logic [rce_pkg::PDATA_W-1:0]  pwdata,
  output logic [rce_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  output rce_pkg::notch_t              notch
);
  import rce_pkg::*;

  logic [ROTOR_W-1:0] reg_idx;
  logic               wr;

  assign reg_idx = paddr[PADDR_W-1:2];
  assign wr      = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      notch <= '0;
    end else if (wr) begin
      case (reg_idx)
        REG_NOTCH_FAST:   notch[0] <= pwdata[LETTER_W-1:0];
        REG_NOTCH_MIDDLE: notch[1] <= pwdata[LETTER_W-1:0];
        REG_NOTCH_SLOW:   notch[2] <= pwdata[LETTER_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_NOTCH_FAST:   prdata = PDATA_W'(notch[0]);
      REG_NOTCH_MIDDLE: prdata = PDATA_W'(notch[1]);
      REG_NOTCH_SLOW:   prdata = PDATA_W'(notch[2]);
      default:          prdata = '0;
    endcase
  end

endmodule

@@ hw/rtl/rce_front.sv @@
// Request front end: rotor stepping, position sets, load checks, input register.
// Depends on rce_pkg and rce_in_if.
`timescale 1ns / 1ps

module rce_front (
  input  logic            clk,
  input  logic            rst,
  input  rce_pkg::notch_t notch,
  rce_in_if.sink          request,
  input  logic            down_ok,
  output logic            valid,
  output rce_pkg::item_t  item
);
  import rce_pkg::*;

  pos_t    pos;
  pos_t    pos_next;
  pos_t    p_step;
  logic    carry_fast;
  logic    carry_mid;
  logic    is_enc;
  logic    load_ok;
  logic    set_ok;
  logic    push;
  logic    accept;
  item_t   item_next;

  assign request.ready = !valid || down_ok;
  assign accept        = request.valid && request.ready;

  // Odometer stepping: a rotor carries only when it lands on its notch.
  always_comb begin
    p_step[0]  = inc26(pos[0]);
    carry_fast = (p_step[0] == notch[0]);
    p_step[1]  = carry_fast ? inc26(pos[1]) : pos[1];
    carry_mid  = carry_fast && (p_step[1] == notch[1]);
    p_step[2]  = carry_mid ? inc26(pos[2]) : pos[2];
  end

  always_comb begin
    is_enc  = (request.command == CMD_ENCRYPT);
    load_ok = (request.command == CMD_LOAD) &&
              (request.entry_index < letter_t'(LETTERS)) &&
              (request.entry_value < letter_t'(LETTERS)) &&
              (request.table_id <= TBL_PLUG);
    set_ok  = (request.command == CMD_SET) &&
              (request.rotor_index < ROTOR_W'(ROTORS)) &&
              (request.start_position < letter_t'(LETTERS));
    push    = is_enc || load_ok;

    pos_next = pos;
    if (accept && is_enc) begin
      pos_next = p_step;
    end
    if (accept && set_ok) begin
      pos_next[request.rotor_index] = request.start_position;
    end

    item_next.is_load  = !is_enc;
    item_next.table_id = request.table_id;
    item_next.idx      = request.entry_index;
    item_next.val      = request.entry_value;
    item_next.sym      = is_enc ? mod26(request.letter) : '0;
    item_next.pos      = p_step;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos   <= '0;
      valid <= 1'b0;
    end else begin
      pos <= pos_next;
      if (request.ready) begin
        valid <= request.valid && push;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (request.ready) begin
      item <= item_next;
    end
  end

endmodule

@@ hw/rtl/rce_stage.sv @@
// One lookup stage: a 26-entry table owned by this stage, offset add/sub, stage register.
// Load items update the table as they pass, so reads and writes stay in item order.
// Depends on rce_pkg.
`timescale 1ns / 1ps

module rce_stage (
  input  logic                clk,
  input  logic                rst,
  input  rce_pkg::stage_cfg_t cfg,
  input  logic                up_valid,
  input  rce_pkg::item_t      up_item,
  output logic                take,
  input  logic                down_ok,
  output logic                valid,
  output rce_pkg::item_t      item
);
  import rce_pkg::*;

  letter_t tbl [LETTERS];
  letter_t p;
  letter_t addr;
  letter_t look;
  letter_t waddr;
  letter_t wdata;
  logic    wr;
  item_t   item_next;

  assign take = !valid || down_ok;

  always_comb begin
    p     = cfg.use_pos ? up_item.pos[cfg.rotor] : '0;
    addr  = add26(up_item.sym, p);
    look  = tbl[addr];
    wr    = take && up_valid && up_item.is_load && (up_item.table_id == cfg.tbl);
    waddr = cfg.inverse ? up_item.val : up_item.idx;
    wdata = cfg.inverse ? up_item.idx : up_item.val;

    item_next = up_item;
    if (!up_item.is_load) begin
      item_next.sym = sub26(look, p);
    end
  end

  always_ff @(posedge clk) begin
    if (rst && cfg.identity_reset) begin
      for (int i = 0; i < LETTERS; i++) begin
        tbl[i] <= letter_t'(i);
      end
    end else if (wr) begin
      tbl[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (take) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item <= item_next;
    end
  end

endmodule

@@ hw/rtl/rotor_cipher_engine.sv @@
// Three-rotor cipher engine: one item per clock unless a stalled result holds the pipeline back.
// The request register steps the rotors and applies position sets; nine lookup
// stages follow (plugboard, fast/middle/slow forward, reflector, slow/middle/fast
// inverse, plugboard), each with its own 26-entry table, so the rate is set by one
// table read plus a mod-26 add and subtract per stage. Load items travel the same
// stages and write each table where it is read, so encrypts always see loads in
// request order. Set items and out-of-range loads or commands give no result.
// Up to 10 items are in flight; a stalled result holds only the stages behind it
// that are full. Reset zeroes the rotor positions and notches and sets both
// plugboard copies to identity; wiring tables hold no reset value.
// Depends on rce_pkg, rce_if, rce_regs, rce_front, rce_stage.
`timescale 1ns / 1ps

module rotor_cipher_engine (
  input  logic                         clk,
  input  logic                         rst,
  rce_in_if.sink                       request,
  rce_out_if.source                    result,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rce_pkg::PADDR_W-1:0]  paddr,
  input  logic [rce_pkg::PDATA_W-1:0]  pwdata,
  output logic [rce_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);
  import rce_pkg::*;

  notch_t notch;
  logic   v    [NUM_STAGES+1];
  item_t  it   [NUM_STAGES+1];
  logic   tk   [NUM_STAGES+1];

  rce_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .notch   (notch)
  );

  rce_front u_front (
    .clk     (clk),
    .rst     (rst),
    .notch   (notch),
    .request (request),
    .down_ok (tk[0]),
    .valid   (v[0]),
    .item    (it[0])
  );

  for (genvar k = 0; k < NUM_STAGES; k++) begin : g_stage
    rce_stage u_stage (
      .clk      (clk),
      .rst      (rst),
      .cfg      (STAGE_CFG[k]),
      .up_valid (v[k]),
      .up_item  (it[k]),
      .take     (tk[k]),
      .down_ok  (tk[k+1]),
      .valid    (v[k+1]),
      .item     (it[k+1])
    );
  end

  assign result.valid         = v[NUM_STAGES] && !it[NUM_STAGES].is_load;
  assign result.cipher_letter = it[NUM_STAGES].sym;
  assign tk[NUM_STAGES]       = !result.valid || result.ready;

endmodule

@@ hw/rtl/rce_checker.sv @@
// Port-level assertions for rotor_cipher_engine, attached by bind.
// Depends on rce_pkg.
`timescale 1ns / 1ps

module rce_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        req_valid,
  input logic                        req_ready,
  input logic [rce_pkg::CMD_W-1:0]   req_command,
  input logic                        res_valid,
  input logic                        res_ready,
  input logic [rce_pkg::LETTER_W-1:0] res_letter
);
  import rce_pkg::*;

  localparam int CNT_W = $clog2(PIPE_DEPTH + 1);

  logic [CNT_W-1:0] outstanding;
  logic             enc_in;
  logic             res_out;

  assign enc_in  = req_valid && req_ready && (req_command == CMD_ENCRYPT);
  assign res_out = res_valid && res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else begin
      outstanding <= CNT_W'(outstanding + CNT_W'(enc_in) - CNT_W'(res_out));
    end
  end

  a_reset_clears: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid right after reset");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_letter))
    else $error("stalled result changed or dropped");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> outstanding != '0)
    else $error("result with no encrypt item outstanding");

  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    outstanding <= CNT_W'(PIPE_DEPTH))
    else $error("more encrypt items in flight than pipeline registers");

endmodule

bind rotor_cipher_engine rce_checker u_rce_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (request.valid),
  .req_ready   (request.ready),
  .req_command (request.command),
  .res_valid   (result.valid),
  .res_ready   (result.ready),
  .res_letter  (result.cipher_letter)
);
